// ----- hdl/itcf_pkg.sv -----
`timescale 1ns / 1ps
package itcf_pkg;

    // Iteration counts
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 16;
    localparam int CALC_STEPS   = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam int SQ_STEPS     = 3;
    localparam int FUSE_OPS     = 6;
    localparam int FUSE_STEPS   = 2 * FUSE_OPS;
    localparam int CNT_W        = 5;

    // Fixed-point constants
    localparam logic [15:0] GRAVITY_UNITS = 16'd1255;
    localparam logic [18:0] GYRO_K        = 19'd480632;
    localparam logic [15:0] ALPHA_RESET   = 16'd64225;
    localparam logic [15:0] THR_RESET     = 16'd128;
    localparam int          CX_W          = 28;

    // Register indexes
    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_THR   = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_CALC,
        ST_FUSE,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        F_PROD,
        F_INC,
        F_PRED,
        F_MUL1,
        F_MUL2,
        F_WRITE
    } fuse_op_t;

    typedef struct packed {
        logic             load;
        logic             sq_en;
        logic             calc_en;
        logic             fuse_en;
        fuse_op_t         op;
        logic             lane;
        logic [CNT_W-1:0] step;
        logic             finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic [21:0] atan_entry(input logic [CNT_W-1:0] i);
        logic [21:0] r;
        case (i)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234379;
            5'd5:    r = 22'd117304;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            5'd20:   r = 22'd4;
            5'd21:   r = 22'd2;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

    // Signed shift with truncation toward zero
    function automatic logic signed [CX_W-1:0] trunc_shift(input logic signed [CX_W-1:0] v,
                                                          input logic [CNT_W-1:0] s);
        logic [CX_W-1:0] m;
        m = v[CX_W-1] ? (~v + 1'b1) : v;
        m = m >> s;
        return v[CX_W-1] ? $signed(~m + 1'b1) : $signed(m);
    endfunction

    // Round to nearest by 2^16, ties away from zero
    function automatic logic signed [33:0] round_sh16(input logic signed [49:0] v);
        logic [49:0] m;
        logic [49:0] r;
        m = v[49] ? (~v + 1'b1) : v;
        r = (m + 50'd32768) >> 16;
        return v[49] ? $signed(~r[33:0] + 1'b1) : $signed(r[33:0]);
    endfunction

    // Angle to 1/64 degree output: round by 2^10 then saturate
    function automatic logic [15:0] tilt_out(input logic signed [31:0] f);
        logic [31:0]        m;
        logic [31:0]        r;
        logic signed [22:0] v;
        logic [15:0]        o;
        m = f[31] ? (~f + 1'b1) : f;
        r = (m + 32'd512) >> 10;
        v = f[31] ? $signed(~r[22:0] + 1'b1) : $signed(r[22:0]);
        if (v > 23'sd32767)
            o = 16'h7fff;
        else if (v < -23'sd32768)
            o = 16'h8000;
        else
            o = v[15:0];
        return o;
    endfunction

endpackage

// ----- hdl/itcf_ctrl.sv -----
`timescale 1ns / 1ps
module itcf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  itcf_pkg::dp_stat_t stat,
    output itcf_pkg::dp_cmd_t  cmd
);
    import itcf_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] fuse_idx;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (s_tvalid)
                    state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (cnt_reg == CNT_W'(SQ_STEPS - 1))
                begin
                    state_next = ST_CALC;
                    cnt_next   = '0;
                end
            end
            ST_CALC:
            begin
                if (cnt_reg == CNT_W'(CALC_STEPS - 1))
                begin
                    state_next = ST_FUSE;
                    cnt_next   = '0;
                end
            end
            ST_FUSE:
            begin
                if (cnt_reg == CNT_W'(FUSE_STEPS - 1))
                begin
                    state_next = ST_DONE;
                    cnt_next   = '0;
                end
            end
            ST_DONE:
            begin
                cnt_next = '0;
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Lane z takes the second half of the fuse steps
    assign fuse_idx = (cnt_reg >= CNT_W'(FUSE_OPS)) ? cnt_reg - CNT_W'(FUSE_OPS) : cnt_reg;

    // Outputs
    always_comb
    begin
        cmd      = '0;
        cmd.op   = fuse_op_t'(fuse_idx[2:0]);
        cmd.lane = (cnt_reg >= CNT_W'(FUSE_OPS));
        cmd.step = cnt_reg;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SQ:   cmd.sq_en   = 1'b1;
            ST_CALC: cmd.calc_en = 1'b1;
            ST_FUSE: cmd.fuse_en = 1'b1;
            ST_DONE: cmd.finish  = stat.out_free;
            default: cmd.load    = 1'b0;
        endcase
    end

endmodule

// ----- hdl/itcf_dp.sv -----
`timescale 1ns / 1ps
module itcf_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [111:0]       s_tdata,
    output logic [47:0]        m_tdata,
    output logic               m_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    input  itcf_pkg::dp_cmd_t  cmd,
    output itcf_pkg::dp_stat_t stat
);
    import itcf_pkg::*;

    // Configuration and filter state
    logic [15:0]        alpha_reg, thr_reg;
    logic               seeded_reg;
    logic signed [31:0] fy_reg, fz_reg;
    logic [31:0]        last_reg;

    // Captured sample
    logic signed [15:0] ax_reg, ay_reg, az_reg, ry_reg, rz_reg;
    logic [31:0]        ts_reg;

    // Magnitude
    logic [31:0] sq_reg;
    logic [32:0] rem_reg, root_reg;

    // CORDIC lanes (0: y tilt, 1: z tilt)
    logic signed [CX_W-1:0] cx_reg [2];
    logic signed [CX_W-1:0] cy_reg [2];
    logic signed [31:0]     cz_reg [2];
    logic                   zero_reg [2];

    // Fuse pipeline registers
    logic signed [48:0] prod_reg;
    logic               neg_reg;
    logic [55:0]        incm_reg;
    logic signed [31:0] pred_reg;
    logic signed [49:0] s1_reg;

    // Output register
    logic [47:0] out_data_reg;
    logic        out_motion_reg;
    logic        out_valid_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            thr_reg   <= THR_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_ALPHA)
                alpha_reg <= cfg_wdata;
            else if (cfg_addr == REG_THR)
                thr_reg <= cfg_wdata;
        end
    end

    // Sample capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= s_tdata[15:0];
            ay_reg <= s_tdata[31:16];
            az_reg <= s_tdata[47:32];
            ry_reg <= s_tdata[63:48];
            rz_reg <= s_tdata[79:64];
            ts_reg <= s_tdata[111:80];
        end
    end

    // Sum of squares, one axis per cycle
    logic signed [15:0] sq_sel;
    logic signed [31:0] sq_term;
    always_comb
    begin
        case (cmd.step[1:0])
            2'd0:    sq_sel = ax_reg;
            2'd1:    sq_sel = ay_reg;
            default: sq_sel = az_reg;
        endcase
        sq_term = sq_sel * sq_sel;
    end

    // Integer square root, one result bit per cycle
    logic [4:0]  sq_sh;
    logic [32:0] sq_bit, sq_trial;
    always_comb
    begin
        sq_sh    = 5'd30 - {cmd.step[3:0], 1'b0};
        sq_bit   = 33'd1 << sq_sh;
        sq_trial = root_reg + sq_bit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sq_reg <= '0;
        else if (cmd.sq_en)
            sq_reg <= sq_reg + $unsigned(sq_term);

        if (cmd.sq_en)
        begin
            rem_reg  <= {1'b0, sq_reg + $unsigned(sq_term)};
            root_reg <= '0;
        end
        else if (cmd.calc_en && (cmd.step < CNT_W'(SQRT_STEPS)))
        begin
            if (rem_reg >= sq_trial)
            begin
                rem_reg  <= rem_reg - sq_trial;
                root_reg <= (root_reg >> 1) + sq_bit;
            end
            else
                root_reg <= root_reg >> 1;
        end
    end

    // CORDIC seed from the incoming sample and vectoring iterations
    logic signed [16:0] in_x, in_y [2];
    logic signed [16:0] sx [2], sy [2];
    logic signed [31:0] sz [2];
    logic               sneg [2];
    logic signed [CX_W-1:0] xs [2], ys [2];
    logic signed [31:0]     atan_v;

    assign in_x    = 17'(signed'(s_tdata[15:0]));
    assign in_y[0] = -17'(signed'(s_tdata[47:32]));
    assign in_y[1] = 17'(signed'(s_tdata[31:16]));
    assign atan_v  = $signed({10'd0, atan_entry(cmd.step)});

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        always_comb
        begin
            sneg[l] = in_x[16];
            sx[l]   = sneg[l] ? -in_x : in_x;
            sy[l]   = sneg[l] ? -in_y[l] : in_y[l];
            if (!sneg[l])
                sz[l] = '0;
            else if (!in_y[l][16])
                sz[l] = 32'sd11796480;
            else
                sz[l] = -32'sd11796480;
            xs[l] = trunc_shift(cx_reg[l], cmd.step);
            ys[l] = trunc_shift(cy_reg[l], cmd.step);
        end

        always_ff @(posedge clk)
        begin
            if (cmd.load)
            begin
                cx_reg[l]   <= CX_W'(signed'({sx[l], 8'd0}));
                cy_reg[l]   <= CX_W'(signed'({sy[l], 8'd0}));
                cz_reg[l]   <= sz[l];
                zero_reg[l] <= (in_x == 17'sd0) && (in_y[l] == 17'sd0);
            end
            else if (cmd.calc_en && (cmd.step < CNT_W'(CORDIC_STEPS)))
            begin
                if (!cy_reg[l][CX_W-1])
                begin
                    cx_reg[l] <= cx_reg[l] + ys[l];
                    cy_reg[l] <= cy_reg[l] - xs[l];
                    cz_reg[l] <= cz_reg[l] + atan_v;
                end
                else
                begin
                    cx_reg[l] <= cx_reg[l] - ys[l];
                    cy_reg[l] <= cy_reg[l] + xs[l];
                    cz_reg[l] <= cz_reg[l] - atan_v;
                end
            end
        end
    end

    // Motion flag from magnitude
    logic [15:0]        mag;
    logic signed [17:0] dev;
    logic [17:0]        dev_abs;
    logic               moving;
    assign mag     = root_reg[15:0];
    assign dev     = $signed({2'b00, mag}) - $signed({2'b00, GRAVITY_UNITS});
    assign dev_abs = dev[17] ? -dev : dev;
    assign moving  = dev_abs > {2'b00, thr_reg};

    // Fuse lane selection
    logic signed [15:0] rate_sel;
    logic signed [31:0] fused_sel, acc_sel;
    logic [31:0]        dt;
    assign rate_sel  = cmd.lane ? rz_reg : ry_reg;
    assign fused_sel = cmd.lane ? fz_reg : fy_reg;
    assign acc_sel   = cmd.lane ? (zero_reg[1] ? 32'sd0 : cz_reg[1])
                                : (zero_reg[0] ? 32'sd0 : cz_reg[0]);
    assign dt        = ts_reg - last_reg;

    // Fuse arithmetic, at most one multiply per step
    logic signed [48:0] prod_next;
    logic [48:0]        prod_mag;
    logic [36:0]        prod_clamp;
    logic [55:0]        incm_next;
    logic [55:0]        inc_round;
    logic signed [41:0] pred_wide;
    logic signed [31:0] pred_next;
    logic signed [49:0] s1_next, s2, sum;
    logic signed [33:0] blend_r;
    logic signed [31:0] blend_sat, fused_new;
    always_comb
    begin
        prod_next  = rate_sel * $signed({1'b0, dt});
        prod_mag   = prod_reg[48] ? 49'(-prod_reg) : 49'(prod_reg);
        prod_clamp = (prod_mag > 49'h10_0000_0000) ? 37'h10_0000_0000 : prod_mag[36:0];
        incm_next  = prod_clamp * GYRO_K;
        inc_round  = (incm_reg + 56'd32768) >> 16;
        pred_wide  = 42'(fused_sel) + (neg_reg ? -$signed({2'b00, inc_round[39:0]})
                                               : $signed({2'b00, inc_round[39:0]}));
        if (pred_wide > 42'sd2147483647)
            pred_next = 32'h7fff_ffff;
        else if (pred_wide < -42'sd2147483648)
            pred_next = 32'h8000_0000;
        else
            pred_next = pred_wide[31:0];
        s1_next = $signed({1'b0, alpha_reg}) * pred_reg;
        s2      = $signed(18'(18'd65536 - {2'b00, alpha_reg})) * acc_sel;
        sum     = s1_reg + s2;
        blend_r = round_sh16(s1_reg);
        if (blend_r > 34'sd2147483647)
            blend_sat = 32'h7fff_ffff;
        else if (blend_r < -34'sd2147483648)
            blend_sat = 32'h8000_0000;
        else
            blend_sat = blend_r[31:0];
        if (!seeded_reg)
            fused_new = acc_sel;
        else if (moving)
            fused_new = pred_reg;
        else
            fused_new = blend_sat;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fuse_en)
        begin
            case (cmd.op)
                F_PROD: prod_reg <= prod_next;
                F_INC:
                begin
                    incm_reg <= incm_next;
                    neg_reg  <= prod_reg[48];
                end
                F_PRED: pred_reg <= pred_next;
                F_MUL1: s1_reg   <= s1_next;
                F_MUL2: s1_reg   <= sum;
                default: ;
            endcase
        end
    end

    // Filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= 1'b0;
            fy_reg     <= '0;
            fz_reg     <= '0;
            last_reg   <= '0;
        end
        else
        begin
            if (cmd.fuse_en && (cmd.op == F_WRITE))
            begin
                if (cmd.lane)
                    fz_reg <= fused_new;
                else
                    fy_reg <= fused_new;
            end
            if (cmd.finish)
            begin
                seeded_reg <= 1'b1;
                last_reg   <= ts_reg;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg   <= {mag, tilt_out(fz_reg), tilt_out(fy_reg)};
            out_motion_reg <= moving;
        end
    end

    assign m_tdata       = out_data_reg;
    assign m_tuser       = out_motion_reg;
    assign m_tvalid      = out_valid_reg;
    assign stat.out_free = !out_valid_reg || m_tready;

endmodule

// ----- hdl/imu_tilt_complementary_filter_core.sv -----
`timescale 1ns / 1ps
// After each input transaction a sample passes through squaring, square root / CORDIC
// iterations, fuse steps and an output load; an output stall can hold the output load back.
// A new sample is taken only in the idle state, after the previous sample has been loaded.
// A new sample is taken while the previous result waits in the output register.
// Reset (rst_n, async active low) restores register defaults and unseeds the filter.
module imu_tilt_complementary_filter_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // accel_x, accel_y, accel_z, rate_y, rate_z, time_ms
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // tilt_y, tilt_z, magnitude
    output logic         m_tuser,   // motion
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);
    import itcf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    itcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    itcf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- hdl/itcf_checker.sv -----
`timescale 1ns / 1ps
module itcf_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [47:0]  m_tdata,
    input logic         m_tuser
);
    // Result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    // Input stall after a transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    // Magnitude bounded by the largest vector length
    a_mag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[47:32] <= 16'd56755)
        else $error("magnitude out of range");

    // A result never appears in the cycle right after an input transaction
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

endmodule

bind imu_tilt_complementary_filter_core itcf_checker u_itcf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
